@@ sv/spd_pkg.sv @@
package spd_pkg;

	// fixed field widths of the stream items
	localparam int DIST_BITS     = 20;
	localparam int VTX_BITS      = 4;
	localparam int W_IN_BITS     = 16;
	localparam int ACT_BITS      = 2;
	localparam int STAT_BITS     = 2;
	localparam int IN_DATA_BITS  = 24;
	localparam int OUT_DATA_BITS = 24;
	localparam int MAX_OUT       = 16;

	localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

	// action codes on the input side
	localparam logic [ACT_BITS-1:0] ACT_SET   = 2'd0;
	localparam logic [ACT_BITS-1:0] ACT_CLEAR = 2'd1;
	localparam logic [ACT_BITS-1:0] ACT_QUERY = 2'd2;

	// result status codes
	localparam logic [STAT_BITS-1:0] STAT_FOUND   = 2'd0;
	localparam logic [STAT_BITS-1:0] STAT_SAME    = 2'd1;
	localparam logic [STAT_BITS-1:0] STAT_UNREACH = 2'd2;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECIDE,
		ST_INIT,
		ST_PASS,
		ST_DRAIN,
		ST_PICK,
		ST_WALK_START,
		ST_WALK,
		ST_EMIT,
		ST_SAME,
		ST_UNREACH
	} state_t;

	typedef enum logic [1:0] {
		SEL_PATH,
		SEL_SAME,
		SEL_UNREACH
	} out_sel_t;

	// controller to datapath
	typedef struct packed {
		logic     in_ready;
		logic     clear_en;
		logic     init;
		logic     issue;
		logic     pick;
		logic     walk_start;
		logic     walk;
		logic     out_load;
		out_sel_t out_sel;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clear_done;
		logic in_query;
		logic q_bad;
		logic q_same;
		logic last_issue;
		logic min_found;
		logic dst_settled;
		logic walk_done;
		logic emit_last;
		logic out_free;
	} dp_stat_t;

endpackage

@@ sv/spd_ctrl.sv @@
module spd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  spd_pkg::dp_stat_t stat,
	output spd_pkg::dp_cmd_t  cmd
);
	import spd_pkg::*;

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear_en = 1'b1;
				if (stat.clear_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				cmd.in_ready = 1'b1;
				if (stat.in_query) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				priority if (stat.q_bad) begin
					state_d = ST_UNREACH;
				end else if (stat.q_same) begin
					state_d = ST_SAME;
				end else begin
					state_d = ST_INIT;
				end
			end
			ST_INIT: begin
				cmd.init = 1'b1;
				state_d  = ST_PASS;
			end
			ST_PASS: begin
				cmd.issue = 1'b1;
				if (stat.last_issue) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_PICK;
			end
			ST_PICK: begin
				if (stat.min_found) begin
					cmd.pick = 1'b1;
					state_d  = ST_PASS;
				end else begin
					state_d = ST_WALK_START;
				end
			end
			ST_WALK_START: begin
				if (stat.dst_settled) begin
					cmd.walk_start = 1'b1;
					state_d        = ST_WALK;
				end else begin
					state_d = ST_UNREACH;
				end
			end
			ST_WALK: begin
				cmd.walk = 1'b1;
				if (stat.walk_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				cmd.out_sel = SEL_PATH;
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					if (stat.emit_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_SAME: begin
				cmd.out_sel = SEL_SAME;
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_UNREACH: begin
				cmd.out_sel = SEL_UNREACH;
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

endmodule

@@ sv/spd_dp.sv @@
module spd_dp #(
	parameter int VERTICES    = 16,
	parameter int WEIGHT_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  spd_pkg::dp_cmd_t                   cmd,
	output spd_pkg::dp_stat_t                  stat,
	input  logic                               s_tvalid,
	input  logic [spd_pkg::IN_DATA_BITS-1:0]   s_tdata,
	input  logic [spd_pkg::ACT_BITS-1:0]       s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [spd_pkg::OUT_DATA_BITS-1:0]  m_tdata,
	output logic [spd_pkg::STAT_BITS-1:0]      m_tuser,
	output logic                               m_tlast
);
	import spd_pkg::*;

	localparam int VW   = $clog2(VERTICES);
	localparam int AW   = 2 * VW;
	localparam int EW   = WEIGHT_BITS + 1;
	localparam int SUMW = ((WEIGHT_BITS > DIST_BITS) ? WEIGHT_BITS : DIST_BITS) + 1;
	localparam int CAP  = (VERTICES < MAX_OUT) ? VERTICES : MAX_OUT;
	localparam int SW   = $clog2(CAP);

	localparam logic [VW-1:0]       V_LAST   = VW'(VERTICES - 1);
	localparam logic [SW-1:0]       CAP_LAST = SW'(CAP - 1);
	localparam logic [VERTICES-1:0] VTX_ONE  = VERTICES'(1);

	// input fields
	logic [VTX_BITS-1:0]  in_from;
	logic [VTX_BITS-1:0]  in_to;
	logic [W_IN_BITS-1:0] in_wt;
	logic [ACT_BITS-1:0]  in_act;
	logic                 in_ok;
	logic                 accept;

	assign in_from = s_tdata[3:0];
	assign in_to   = s_tdata[7:4];
	assign in_wt   = s_tdata[23:8];
	assign in_act  = s_tuser;
	assign in_ok   = (32'(in_from) < VERTICES) && (32'(in_to) < VERTICES);
	assign accept  = s_tvalid && cmd.in_ready;

	// query fields held for the search
	logic [VW-1:0]       src_q;
	logic [VW-1:0]       dst_q;
	logic [VTX_BITS-1:0] src_raw_q;
	logic                ok_q;
	logic                same_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			src_q     <= VW'(in_from);
			dst_q     <= VW'(in_to);
			src_raw_q <= in_from;
			ok_q      <= in_ok;
			same_q    <= (in_from == in_to);
		end
	end

	// edge matrix, row is the start vertex
	logic [EW-1:0] edge_mem [2**AW];
	logic [EW-1:0] edge_rd_s1;
	logic [AW-1:0] clr_q;
	logic          edge_we;
	logic [AW-1:0] edge_wa;
	logic [EW-1:0] edge_wd;
	logic [VW-1:0] v_q;
	logic [VW-1:0] w_q;

	assign edge_we = cmd.clear_en ||
		(accept && in_ok && ((in_act == ACT_SET) || (in_act == ACT_CLEAR)));
	assign edge_wa = cmd.clear_en ? clr_q : {VW'(in_from), VW'(in_to)};
	assign edge_wd = (!cmd.clear_en && (in_act == ACT_SET)) ?
		{1'b1, WEIGHT_BITS'(in_wt)} : '0;

	always_ff @(posedge clk) begin
		if (edge_we) begin
			edge_mem[edge_wa] <= edge_wd;
		end
		edge_rd_s1 <= edge_mem[{v_q, w_q}];
	end

	// per-vertex distance and predecessor
	logic [DIST_BITS-1:0] dist_mem [VERTICES];
	logic [VW-1:0]        pred_mem [VERTICES];
	logic [DIST_BITS-1:0] dist_rd_s1;
	logic [VW-1:0]        pred_rd_q;
	logic [VW-1:0]        dist_ra;
	logic                 tab_we;
	logic [VW-1:0]        tab_wa;
	logic [DIST_BITS-1:0] dist_wd;
	logic [VW-1:0]        pred_wd;
	logic [VW-1:0]        cur_w;
	logic [VW-1:0]        w_s1;
	logic                 upd;
	logic [DIST_BITS-1:0] cand;

	assign dist_ra = cmd.walk_start ? dst_q : w_q;
	assign tab_we  = cmd.init || upd;
	assign tab_wa  = cmd.init ? src_q : w_s1;
	assign dist_wd = cmd.init ? '0 : cand;
	assign pred_wd = cmd.init ? src_q : v_q;

	always_ff @(posedge clk) begin
		if (tab_we) begin
			dist_mem[tab_wa] <= dist_wd;
			pred_mem[tab_wa] <= pred_wd;
		end
		dist_rd_s1 <= dist_mem[dist_ra];
		pred_rd_q  <= pred_mem[cur_w];
	end

	// relaxation of one neighbor and running minimum for the next pick
	logic [VERTICES-1:0]  reached_q;
	logic [VERTICES-1:0]  settled_q;
	logic                 vld_s1;
	logic [DIST_BITS-1:0] dv_q;
	logic                 min_found_q;
	logic [VW-1:0]        min_idx_q;
	logic [DIST_BITS-1:0] min_dist_q;
	logic [SUMW-1:0]      sum;
	logic                 e_valid;
	logic                 w_settled;
	logic                 w_reached;
	logic [DIST_BITS-1:0] new_d;
	logic                 cand_ok;
	logic                 take_min;

	assign e_valid   = edge_rd_s1[WEIGHT_BITS];
	assign sum       = SUMW'(dv_q) + SUMW'(edge_rd_s1[WEIGHT_BITS-1:0]);
	assign cand      = (sum > SUMW'(DIST_MAX)) ? DIST_MAX : sum[DIST_BITS-1:0];
	assign w_settled = settled_q[w_s1];
	assign w_reached = reached_q[w_s1];
	assign upd       = vld_s1 && !w_settled && e_valid &&
		(!w_reached || (cand < dist_rd_s1));
	assign new_d     = upd ? cand : dist_rd_s1;
	assign cand_ok   = vld_s1 && !w_settled && (w_reached || upd);
	assign take_min  = cand_ok && (!min_found_q || (new_d < min_dist_q));

	// path stack, filled from the destination back
	logic [VW-1:0]        stack_q [CAP];
	logic [SW-1:0]        sp_q;
	logic                 first_q;
	logic [DIST_BITS-1:0] total_q;
	logic                 walk_done;
	logic                 pop;

	assign cur_w     = first_q ? dst_q : pred_rd_q;
	assign walk_done = (cur_w == src_q) || (sp_q == CAP_LAST);
	assign pop       = cmd.out_load && (cmd.out_sel == SEL_PATH);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			reached_q   <= '0;
			settled_q   <= '0;
			vld_s1      <= 1'b0;
			min_found_q <= 1'b0;
		end else begin
			if (cmd.clear_en) begin
				clr_q <= clr_q + 1'b1;
			end
			vld_s1 <= cmd.issue;
			if (cmd.init) begin
				reached_q   <= VTX_ONE << src_q;
				settled_q   <= VTX_ONE << src_q;
				min_found_q <= 1'b0;
			end else if (cmd.pick) begin
				settled_q[min_idx_q] <= 1'b1;
				min_found_q          <= 1'b0;
			end else begin
				if (upd) begin
					reached_q[w_s1] <= 1'b1;
				end
				if (take_min) begin
					min_found_q <= 1'b1;
				end
			end
		end
	end

	// search and walk payload registers
	always_ff @(posedge clk) begin
		w_s1 <= w_q;
		if (cmd.init) begin
			v_q  <= src_q;
			dv_q <= '0;
			w_q  <= '0;
		end else if (cmd.pick) begin
			v_q  <= min_idx_q;
			dv_q <= min_dist_q;
			w_q  <= '0;
		end else if (cmd.issue) begin
			w_q <= w_q + 1'b1;
		end
		if (take_min) begin
			min_idx_q  <= w_s1;
			min_dist_q <= new_d;
		end
		if (cmd.walk_start) begin
			sp_q    <= '0;
			first_q <= 1'b1;
		end else if (cmd.walk) begin
			stack_q[sp_q] <= cur_w;
			first_q       <= 1'b0;
			if (first_q) begin
				total_q <= dist_rd_s1;
			end
			if (!walk_done) begin
				sp_q <= sp_q + 1'b1;
			end
		end else if (pop) begin
			sp_q <= sp_q - 1'b1;
		end
	end

	// output register
	logic                 out_valid_q;
	logic [VTX_BITS-1:0]  out_vtx_q;
	logic [DIST_BITS-1:0] out_dist_q;
	logic [STAT_BITS-1:0] out_stat_q;
	logic                 out_last_q;
	logic                 out_free;

	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			unique case (cmd.out_sel)
				SEL_PATH: begin
					out_vtx_q  <= VTX_BITS'(stack_q[sp_q]);
					out_dist_q <= total_q;
					out_stat_q <= STAT_FOUND;
					out_last_q <= (sp_q == '0);
				end
				SEL_SAME: begin
					out_vtx_q  <= src_raw_q;
					out_dist_q <= '0;
					out_stat_q <= STAT_SAME;
					out_last_q <= 1'b1;
				end
				default: begin
					out_vtx_q  <= '0;
					out_dist_q <= '0;
					out_stat_q <= STAT_UNREACH;
					out_last_q <= 1'b1;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_dist_q, out_vtx_q};
	assign m_tuser  = out_stat_q;
	assign m_tlast  = out_last_q;

	// status to the controller
	always_comb begin
		stat             = '0;
		stat.clear_done  = &clr_q;
		stat.in_query    = s_tvalid && (in_act == ACT_QUERY);
		stat.q_bad       = !ok_q;
		stat.q_same      = same_q;
		stat.last_issue  = (w_q == V_LAST);
		stat.min_found   = min_found_q;
		stat.dst_settled = settled_q[dst_q];
		stat.walk_done   = walk_done;
		stat.emit_last   = (sp_q == '0);
		stat.out_free    = out_free;
	end

endmodule

@@ sv/shortest_path_dijkstra_matrix.sv @@
// Shortest path over a directed graph held as a VERTICES x VERTICES weight matrix.
// Input channel s_*: one transfer is one action. s_tuser carries the action
// (set edge, clear edge, query); s_tdata carries from, to and weight.
// Edge actions give no result. A query runs Dijkstra from
// the source and returns the path source first on m_*, one transfer per vertex,
// every one carrying the total distance, m_tlast on the final one. A query with
// equal ends, a vertex out of range or no path gives one status transfer.
// Query steps: each settled vertex costs one sweep of its matrix row through
// the single read port of the weight memory, then the predecessors are walked
// back from the destination and the results are sent.
// One query is in flight at a time; s_tready is high only between queries.
// After reset the weight memory is swept to no-edge, every one of its
// 2**(2*ceil(log2 VERTICES)) entries (256 at 16 vertices), with s_tready low.
// Results sit in an output register: a stalled m_tready holds the current
// result and pauses the block, and the next action is taken while the final
// result still waits.
module shortest_path_dijkstra_matrix #(
	parameter int VERTICES    = 16,
	parameter int WEIGHT_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// from_vertex[3:0], to_vertex[7:4], weight[23:8]
	input  logic [spd_pkg::IN_DATA_BITS-1:0]   s_tdata,
	// action[1:0]
	input  logic [spd_pkg::ACT_BITS-1:0]       s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// path_vertex[3:0], total_distance[23:4]
	output logic [spd_pkg::OUT_DATA_BITS-1:0]  m_tdata,
	// status[1:0]
	output logic [spd_pkg::STAT_BITS-1:0]      m_tuser,
	output logic                               m_tlast
);
	import spd_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	spd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	spd_dp #(
		.VERTICES    (VERTICES),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.s_tvalid (s_tvalid),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	assign s_tready = cmd.in_ready;

	// no input transfer while the matrix is swept or a row is scanned
	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.clear_en || cmd.issue) |-> !s_tready)
		else $error("input ready during clear sweep or search pass");

	// a pending result is never overwritten
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_tvalid || m_tready))
		else $error("output register loaded while a result waits");

	// status results stand alone
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser != STAT_FOUND)) |-> m_tlast)
		else $error("status result without last");

	// the walk only starts from a settled destination
	a_walk_settled: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk_start |-> stat.dst_settled)
		else $error("path walk from unsettled destination");

endmodule

@@ verif/tb_shortest_path_dijkstra_matrix.sv @@
`timescale 1ns / 1ps

module tb_shortest_path_dijkstra_matrix;

	import spd_pkg::*;

	localparam int NV = 16;
	localparam int HOLD_CYCLES = 1500;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int TAIL_CYCLES = 400;
	localparam int MAX_REPORTS = 50;

	// the one action code the block ignores
	localparam logic [ACT_BITS-1:0] ACT_UNKNOWN = 2'd3;

	// one path transfer as seen on the master side
	typedef struct packed {
		logic [VTX_BITS-1:0]  vertex;
		logic [DIST_BITS-1:0] total;
		logic [STAT_BITS-1:0] status;
		logic                 last;
	} route_step_t;

	// mirror of the weight matrix plus the queue of expected path transfers
	class route_scoreboard;
		bit [W_IN_BITS:0] arc_weight [NV][NV];
		route_step_t      route_steps [$];
		int               errors;
		int               actions;
		int               queries;
		int               steps_checked;

		function int pending();
			return route_steps.size();
		endfunction

		task report_mismatch(input string msg);
			if (errors < MAX_REPORTS)
				$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task push_step(input bit [3:0] v, input bit [19:0] d, input bit [1:0] st, input bit l);
			route_step_t step;
			step.vertex = v;
			step.total  = d;
			step.status = st;
			step.last   = l;
			route_steps.push_back(step);
		endtask

		// dijkstra from src, lowest index wins ties, then the path src first
		task plan_route(input bit [3:0] src, input bit [3:0] dst);
			bit [DIST_BITS-1:0] path_dist [NV];
			bit [3:0]           pred [NV];
			bit                 reached [NV];
			bit                 done [NV];
			bit [3:0]           trail [NV];
			bit [DIST_BITS-1:0] best;
			bit [DIST_BITS:0]   cand;
			bit [3:0]           cur;
			bit                 found;
			int                 i;
			int                 w;
			int                 v;
			int                 count;
			if (src == dst) begin
				push_step(src, '0, STAT_SAME, 1'b1);
				return;
			end
			for (i = 0; i < NV; i++) begin
				reached[i]   = 1'b0;
				done[i]      = 1'b0;
				path_dist[i] = '0;
				pred[i]      = '0;
			end
			path_dist[src] = '0;
			pred[src]      = src;
			reached[src]   = 1'b1;
			for (i = 0; i < NV; i++) begin
				found = 1'b0;
				best  = '0;
				v     = 0;
				for (w = 0; w < NV; w++) begin
					if (reached[w] && !done[w] && (!found || path_dist[w] < best)) begin
						found = 1'b1;
						best  = path_dist[w];
						v     = w;
					end
				end
				if (!found)
					break;
				done[v] = 1'b1;
				// relax the row of the settled vertex, saturating sums
				for (w = 0; w < NV; w++) begin
					if (!done[w] && arc_weight[v][w][W_IN_BITS]) begin
						cand = best + arc_weight[v][w][W_IN_BITS-1:0];
						if (cand > DIST_MAX)
							cand = DIST_MAX;
						if (!reached[w] || cand < path_dist[w]) begin
							path_dist[w] = cand[DIST_BITS-1:0];
							pred[w]      = v[3:0];
							reached[w]   = 1'b1;
						end
					end
				end
			end
			if (!done[dst]) begin
				push_step('0, '0, STAT_UNREACH, 1'b1);
				return;
			end
			// walk predecessors back from the destination
			count = 0;
			cur   = dst;
			while (count < NV) begin
				trail[count] = cur;
				count++;
				if (cur == src)
					break;
				cur = pred[cur];
			end
			for (i = 0; i < count; i++)
				push_step(trail[count-1-i], path_dist[dst], STAT_FOUND, i == count - 1);
		endtask

		task note_action(input logic [1:0] act, input logic [3:0] from_v,
				input logic [3:0] to_v, input logic [15:0] wt);
			if (act == ACT_SET)
				arc_weight[from_v][to_v] = {1'b1, wt};
			else if (act == ACT_CLEAR)
				arc_weight[from_v][to_v] = '0;
			else if (act == ACT_QUERY) begin
				queries++;
				plan_route(from_v, to_v);
			end
			if (act != ACT_UNKNOWN)
				actions++;
		endtask

		task check_result(input route_step_t got);
			route_step_t want;
			if (route_steps.size() == 0) begin
				report_mismatch($sformatf("unexpected transfer vertex %0d dist %0d status %0d",
					got.vertex, got.total, got.status));
				return;
			end
			want = route_steps.pop_front();
			steps_checked++;
			if (got.vertex !== want.vertex)
				report_mismatch($sformatf("path_vertex %0d, expected %0d", got.vertex, want.vertex));
			if (got.total !== want.total)
				report_mismatch($sformatf("total_distance %0d, expected %0d", got.total, want.total));
			if (got.status !== want.status)
				report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
			if (got.last !== want.last)
				report_mismatch($sformatf("tlast %0d, expected %0d", got.last, want.last));
		endtask
	endclass

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     s_tvalid;
	logic                     s_tready;
	logic [IN_DATA_BITS-1:0]  s_tdata;
	logic [ACT_BITS-1:0]      s_tuser;
	logic                     m_tvalid;
	logic                     m_tready;
	logic [OUT_DATA_BITS-1:0] m_tdata;
	logic [STAT_BITS-1:0]     m_tuser;
	logic                     m_tlast;

	route_scoreboard board;
	bit              quiet;
	bit              hold_req;
	int              cycle_count;

	shortest_path_dijkstra_matrix u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #10 clk = ~clk;

	// one action transfer, with random idle cycles ahead of it
	task send_action(input logic [1:0] act, input logic [3:0] from_v,
			input logic [3:0] to_v, input logic [15:0] wt);
		while (!quiet && $urandom_range(99) < 6) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {wt, to_v, from_v};
		s_tuser  <= act;
		do @(posedge clk); while (!s_tready);
		board.note_action(act, from_v, to_v, wt);
	endtask

	function logic [15:0] rand_weight();
		int r;
		r = $urandom_range(3);
		if (r == 0)
			return 16'($urandom_range(15));
		else if (r == 1)
			return 16'($urandom_range(255));
		else if (r == 2)
			return 16'($urandom_range(65535));
		return ($urandom_range(1) == 1) ? 16'hffff : 16'h0000;
	endfunction

	// chain of distinct vertices with random weights, then query its ends and a random pair
	task chain_round();
		logic [3:0] perm [NV];
		logic [3:0] tmp;
		int         len;
		int         i;
		int         j;
		for (i = 0; i < NV; i++)
			perm[i] = i[3:0];
		for (i = NV - 1; i > 0; i--) begin
			j       = $urandom_range(i);
			tmp     = perm[i];
			perm[i] = perm[j];
			perm[j] = tmp;
		end
		len = ($urandom_range(9) == 0) ? NV : $urandom_range(6, 2);
		for (i = 0; i < len - 1; i++)
			send_action(ACT_SET, perm[i], perm[i+1], rand_weight());
		send_action(ACT_QUERY, perm[0], perm[len-1], '0);
		send_action(ACT_QUERY, 4'($urandom_range(15)), 4'($urandom_range(15)),
			16'($urandom_range(65535)));
	endtask

	// single random action, now and then a whole row cleared
	task noise_round();
		int         r;
		int         j;
		logic [3:0] row;
		r = $urandom_range(19);
		if (r < 8)
			send_action(ACT_SET, 4'($urandom_range(15)), 4'($urandom_range(15)),
				rand_weight());
		else if (r < 12)
			send_action(ACT_CLEAR, 4'($urandom_range(15)), 4'($urandom_range(15)),
				16'($urandom_range(65535)));
		else if (r < 17)
			send_action(ACT_QUERY, 4'($urandom_range(15)), 4'($urandom_range(15)),
				16'($urandom_range(65535)));
		else if (r < 18)
			send_action(ACT_UNKNOWN, 4'($urandom_range(15)), 4'($urandom_range(15)),
				16'($urandom_range(65535)));
		else begin
			row = 4'($urandom_range(15));
			for (j = 0; j < NV; j++)
				send_action(ACT_CLEAR, row, j[3:0], '0);
		end
	endtask

	// master side: check each transfer, random and long stalls
	initial begin : result_sink
		int hold_left;
		hold_left = 0;
		m_tready  = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready)
				board.check_result({m_tdata[3:0], m_tdata[23:4], m_tuser, m_tlast});
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else
				m_tready <= quiet || ($urandom_range(99) >= 6);
		end
	end

	// run limit
	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", cycle_count);
		$display("simulation failed");
		$finish;
	end

	initial begin : stimulus
		bit hold_done;
		bit drain_done;
		board      = new();
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = '0;
		quiet      = 1'b0;
		hold_req   = 1'b0;
		hold_done  = 1'b0;
		drain_done = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty graph, same point, weight extremes, ties, clears, ignored code
		send_action(ACT_QUERY, 4'd0, 4'd5, 16'h0000);
		send_action(ACT_QUERY, 4'd7, 4'd7, 16'hffff);
		send_action(ACT_QUERY, 4'd15, 4'd15, 16'h0000);
		send_action(ACT_SET, 4'd0, 4'd1, 16'h0000);
		send_action(ACT_SET, 4'd1, 4'd15, 16'hffff);
		send_action(ACT_SET, 4'd0, 4'd15, 16'hffff);
		send_action(ACT_SET, 4'd5, 4'd5, 16'h0003);
		send_action(ACT_QUERY, 4'd0, 4'd15, 16'h0000);
		send_action(ACT_SET, 4'd15, 4'd14, 16'hffff);
		send_action(ACT_UNKNOWN, 4'd14, 4'd0, 16'h0001);
		send_action(ACT_QUERY, 4'd0, 4'd14, 16'h0000);
		send_action(ACT_QUERY, 4'd14, 4'd0, 16'h0000);
		send_action(ACT_SET, 4'd14, 4'd5, 16'h0001);
		send_action(ACT_QUERY, 4'd1, 4'd5, 16'h0000);
		send_action(ACT_CLEAR, 4'd0, 4'd15, 16'hffff);
		send_action(ACT_CLEAR, 4'd1, 4'd15, 16'h0000);
		send_action(ACT_QUERY, 4'd0, 4'd15, 16'h0000);
		send_action(ACT_QUERY, 4'd15, 4'd5, 16'h0000);

		// random part, mostly chains with random content
		while (board.actions < 370) begin
			quiet = (board.actions >= 180 && board.actions < 260);
			if (!hold_done && board.actions >= 100) begin
				// output held off while actions keep coming
				hold_done = 1'b1;
				hold_req  = 1'b1;
				repeat (3) chain_round();
			end else if (!drain_done && board.actions >= 300) begin
				// sender waits for every expected path transfer
				drain_done = 1'b1;
				s_tvalid <= 1'b0;
				do @(posedge clk); while (board.pending() != 0);
			end else if ($urandom_range(9) < 6)
				chain_round();
			else
				noise_round();
		end
		quiet = 1'b0;
		s_tvalid <= 1'b0;

		// drain, then watch for stray transfers
		do @(posedge clk); while (board.pending() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (board.pending() != 0)
			board.report_mismatch($sformatf("%0d path transfers never came", board.pending()));
		$display("covered %0d actions, %0d queries, %0d path transfers checked,",
			board.actions, board.queries, board.steps_checked);
		$display("with random stalls, one long output hold-off and one full drain");
		if (board.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/spd_pkg.sv
sv/spd_ctrl.sv
sv/spd_dp.sv
sv/shortest_path_dijkstra_matrix.sv
verif/tb_shortest_path_dijkstra_matrix.sv
